// File: rtl/core/boot_tag_list_parser_macros.svh
// Assertion macros for the boot tag list parser.
// Used by modules that declare clk_i and rst_ni; no other dependencies.
`ifndef BOOT_TAG_LIST_PARSER_MACROS_SVH
`define BOOT_TAG_LIST_PARSER_MACROS_SVH

// Check that cond holds whenever ante holds.
`define BTLP_ASSERT_IMP(lbl, ante, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cond)) \
    else $error(msg);

// Check that expr holds at every edge.
`define BTLP_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error(msg);

`endif

// File: rtl/core/btlp_pkg.sv
// Shared types and constants for the boot tag list parser.
// No dependencies.
`default_nettype none

package btlp_pkg;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HDR,
    PH_TYPE,
    PH_SIZE,
    PH_BODY
  } phase_e;

  typedef enum logic [1:0] {
    CL_OTHER,
    CL_MMAP,
    CL_ELF,
    CL_END
  } class_e;

  localparam logic [31:0] TAG_TYPE_END  = 32'd0;
  localparam logic [31:0] TAG_TYPE_MMAP = 32'd6;
  localparam logic [31:0] TAG_TYPE_ELF  = 32'd9;
  localparam logic [31:0] REGION_AVAIL  = 32'd1;
  localparam logic [31:0] MIN_TAG_SIZE  = 32'd8;

  // word positions inside a memory-map entry
  localparam logic [3:0] MM_ADDR_LO = 4'd0;
  localparam logic [3:0] MM_ADDR_HI = 4'd1;
  localparam logic [3:0] MM_LEN_LO  = 4'd2;
  localparam logic [3:0] MM_LEN_HI  = 4'd3;
  localparam logic [3:0] MM_TYPE    = 4'd4;
  localparam logic [3:0] MM_LAST    = 4'd5;

  // word positions inside an ELF section entry
  localparam logic [3:0] ELF_ADDR_LO = 4'd4;
  localparam logic [3:0] ELF_ADDR_HI = 4'd5;
  localparam logic [3:0] ELF_SIZE_LO = 4'd8;
  localparam logic [3:0] ELF_SIZE_HI = 4'd9;
  localparam logic [3:0] ELF_LAST    = 4'd15;

  typedef struct packed {
    logic       clear;
    logic       tag_begin;
    logic       size_err;
    logic       mmap_we;
    logic       elf_we;
    logic       elf_counted;
    logic [3:0] word;
    logic       finish;
    logic       mismatch;
  } walk_ctl_t;

  typedef struct packed {
    logic [63:0] region_one_base;
    logic [63:0] region_one_length;
    logic [63:0] region_two_base;
    logic [63:0] region_two_length;
    logic [1:0]  regions_found;
    logic        extra_regions;
    logic [63:0] elf_low_address;
    logic [63:0] elf_high_address;
    logic        length_mismatch;
    logic        bad_tag_size;
  } summary_t;

endpackage

`default_nettype wire

// File: rtl/core/boot_tag_list_parser.sv
// Boot tag list parser, top level.
// Uses btlp_pkg, btlp_in_stage, btlp_walker, btlp_collect, btlp_out_stage.
//
// Input channel: one 32-bit little-endian word of the boot information list
// per beat (data_word_i); first_word_i marks word 0 of a new list and restarts
// the walk, dropping any list in progress. Words outside a list are dropped.
// Output channel: one summary beat per list, sent when the walk ends at a
// terminator tag, on reaching or passing the total length, or at a tag of bad size.
// Path: a word is held in the input register, and the summary it ends is
// loaded from there into the result register, which drives out_valid_o.
// Throughput: one word per cycle while the result register is not stalled,
// set by the single update of the walker and collector state per word.
// Stall: while a summary waits under out_stall_i, the input register holds its
// word and in_stall_o is high once that register is full; otherwise words flow
// every cycle.
// Reset: asynchronous, active low; both channels empty, walker idle, ELF low
// bound all ones and every other walker and collector field zero.
`default_nettype none

module boot_tag_list_parser
  import btlp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [31:0] data_word_i,
  input  wire logic        first_word_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [63:0]      region_one_base_o,
  output logic [63:0]      region_one_length_o,
  output logic [63:0]      region_two_base_o,
  output logic [63:0]      region_two_length_o,
  output logic [1:0]       regions_found_o,
  output logic             extra_regions_o,
  output logic [63:0]      elf_low_address_o,
  output logic [63:0]      elf_high_address_o,
  output logic             length_mismatch_o,
  output logic             bad_tag_size_o
);

  logic        advance;
  logic        word_valid;
  logic [31:0] word;
  logic        first;
  logic        fire;
  walk_ctl_t   ctl;
  summary_t    sum_next;
  summary_t    sum_out;

  btlp_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .data_word_i  (data_word_i),
    .first_word_i (first_word_i),
    .advance_i    (advance),
    .valid_o      (word_valid),
    .word_o       (word),
    .first_o      (first)
  );

  assign fire = word_valid & advance;

  btlp_walker u_walker (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .word_i (word),
    .first_i(first),
    .ctl_o  (ctl)
  );

  btlp_collect u_collect (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .word_i (word),
    .ctl_i  (ctl),
    .sum_o  (sum_next)
  );

  btlp_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire & ctl.finish),
    .sum_i       (sum_next),
    .advance_o   (advance),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sum_o       (sum_out)
  );

  assign region_one_base_o   = sum_out.region_one_base;
  assign region_one_length_o = sum_out.region_one_length;
  assign region_two_base_o   = sum_out.region_two_base;
  assign region_two_length_o = sum_out.region_two_length;
  assign regions_found_o     = sum_out.regions_found;
  assign extra_regions_o     = sum_out.extra_regions;
  assign elf_low_address_o   = sum_out.elf_low_address;
  assign elf_high_address_o  = sum_out.elf_high_address;
  assign length_mismatch_o   = sum_out.length_mismatch;
  assign bad_tag_size_o      = sum_out.bad_tag_size;

endmodule

`default_nettype wire

// File: rtl/core/btlp_in_stage.sv
// Input register for the tag list word channel.
// Depends on nothing but the clock and reset.
`default_nettype none

module btlp_in_stage (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [31:0] data_word_i,
  input  wire logic        first_word_i,
  input  wire logic        advance_i,
  output logic             valid_o,
  output logic [31:0]      word_o,
  output logic             first_o
);

  logic        valid_q, valid_d;
  logic [31:0] word_q;
  logic        first_q;

  assign in_stall_o = valid_q & ~advance_i;
  assign valid_d    = in_stall_o ? valid_q : in_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      word_q  <= data_word_i;
      first_q <= first_word_i;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;
  assign first_o = first_q;

endmodule

`default_nettype wire

// File: rtl/core/btlp_walker.sv
// Tag walker: byte position, tag boundaries and entry counting.
// Depends on btlp_pkg and boot_tag_list_parser_macros.svh.
`default_nettype none
`include "boot_tag_list_parser_macros.svh"

module btlp_walker
  import btlp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        fire_i,
  input  wire logic [31:0] word_i,
  input  wire logic        first_i,
  output walk_ctl_t        ctl_o
);

  phase_e      phase_q, phase_d;
  class_e      class_q, class_d;
  logic [31:0] pos_q, pos_d;
  logic [31:0] total_q, total_d;
  logic [31:0] start_q, start_d;
  logic [31:0] tlen_q, tlen_d;
  logic [31:0] size_q, size_d;
  logic [32:0] mm_end_q, mm_end_d;
  logic [3:0]  word_q, word_d;
  logic [25:0] cnt_q, cnt_d;
  logic [25:0] idx_q, idx_d;

  logic [31:0] adj;
  logic [32:0] size_end;
  logic [32:0] start8;
  logic [31:0] pos4;
  logic [31:0] off;
  logic [31:0] elf_room;
  logic        step_tag;
  logic [31:0] nf_pos;
  logic        nf_wrap;
  walk_ctl_t   ctl;

  assign adj      = (word_i + 32'd7) & ~32'd7;
  assign size_end = {1'b0, start_q} + {1'b0, adj};
  assign start8   = {1'b0, start_q} + 33'd8;
  assign pos4     = pos_q + 32'd4;
  assign off      = pos_q - start_q;
  assign elf_room = word_i - 32'd20;

  always_comb begin
    phase_d  = phase_q;
    class_d  = class_q;
    pos_d    = pos_q;
    total_d  = total_q;
    start_d  = start_q;
    tlen_d   = tlen_q;
    size_d   = size_q;
    mm_end_d = mm_end_q;
    word_d   = word_q;
    cnt_d    = cnt_q;
    idx_d    = idx_q;
    ctl      = '0;
    ctl.word = word_q;
    ctl.elf_counted = (idx_q != 26'd0);
    step_tag = 1'b0;
    nf_pos   = pos_q;
    nf_wrap  = 1'b0;

    if (fire_i) begin
      if (first_i) begin
        ctl.clear = 1'b1;
        phase_d   = PH_HDR;
        class_d   = CL_OTHER;
        pos_d     = 32'd4;
        total_d   = word_i;
        start_d   = '0;
        tlen_d    = '0;
        size_d    = '0;
        mm_end_d  = '0;
        word_d    = '0;
        cnt_d     = '0;
        idx_d     = '0;
      end else begin
        case (phase_q)
          PH_HDR: begin
            step_tag = 1'b1;
            nf_pos   = 32'd8;
          end
          PH_TYPE: begin
            if (word_i == TAG_TYPE_END) begin
              class_d = CL_END;
            end else if (word_i == TAG_TYPE_MMAP) begin
              class_d = CL_MMAP;
            end else if (word_i == TAG_TYPE_ELF) begin
              class_d = CL_ELF;
            end else begin
              class_d = CL_OTHER;
            end
            pos_d   = pos4;
            phase_d = PH_SIZE;
          end
          PH_SIZE: begin
            if (word_i < MIN_TAG_SIZE || adj == 32'd0) begin
              ctl.size_err = 1'b1;
              ctl.finish   = 1'b1;
              ctl.mismatch = (pos4 != total_q);
              pos_d        = pos4;
              phase_d      = PH_IDLE;
            end else if (class_q == CL_END) begin
              tlen_d       = adj;
              pos_d        = size_end[31:0];
              ctl.finish   = 1'b1;
              ctl.mismatch = size_end[32] || (size_end[31:0] != total_q);
              phase_d      = PH_IDLE;
            end else begin
              tlen_d        = adj;
              size_d        = word_i;
              mm_end_d      = 33'd40;
              word_d        = '0;
              idx_d         = '0;
              cnt_d         = (class_q == CL_ELF && word_i >= 32'd20) ? elf_room[31:6] : '0;
              ctl.tag_begin = 1'b1;
              phase_d       = PH_BODY;
              pos_d         = pos4;
              if (adj == MIN_TAG_SIZE) begin
                step_tag = 1'b1;
                nf_pos   = start8[31:0];
                nf_wrap  = start8[32];
              end
            end
          end
          PH_BODY: begin
            if (class_q == CL_MMAP) begin
              if (off >= 32'd16 && mm_end_q <= {1'b0, size_q}) begin
                ctl.mmap_we = 1'b1;
                if (word_q == MM_LAST) begin
                  word_d   = '0;
                  mm_end_d = mm_end_q + 33'd24;
                end else begin
                  word_d = word_q + 4'd1;
                end
              end
            end else if (class_q == CL_ELF) begin
              if (off == 32'd8) begin
                if (word_i < {6'd0, cnt_q}) begin
                  cnt_d = word_i[25:0];
                end
              end else if (off >= 32'd20 && idx_q < cnt_q) begin
                ctl.elf_we = 1'b1;
                word_d     = word_q + 4'd1;
                if (word_q == ELF_LAST) begin
                  idx_d = idx_q + 26'd1;
                end
              end
            end
            pos_d = pos4;
            if (pos4 - start_q == tlen_q) begin
              step_tag = 1'b1;
              nf_pos   = pos4;
              nf_wrap  = (pos4 < start_q);
            end
          end
          default: begin
          end
        endcase

        if (step_tag) begin
          pos_d = nf_pos;
          if (!nf_wrap && nf_pos < total_q) begin
            start_d = nf_pos;
            phase_d = PH_TYPE;
          end else begin
            ctl.finish   = 1'b1;
            ctl.mismatch = nf_wrap || (nf_pos != total_q);
            phase_d      = PH_IDLE;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      class_q  <= CL_OTHER;
      pos_q    <= '0;
      total_q  <= '0;
      start_q  <= '0;
      tlen_q   <= '0;
      size_q   <= '0;
      mm_end_q <= '0;
      word_q   <= '0;
      cnt_q    <= '0;
      idx_q    <= '0;
    end else begin
      phase_q  <= phase_d;
      class_q  <= class_d;
      pos_q    <= pos_d;
      total_q  <= total_d;
      start_q  <= start_d;
      tlen_q   <= tlen_d;
      size_q   <= size_d;
      mm_end_q <= mm_end_d;
      word_q   <= word_d;
      cnt_q    <= cnt_d;
      idx_q    <= idx_d;
    end
  end

  assign ctl_o = ctl;

  `BTLP_ASSERT_IMP(a_finish_active, ctl.finish, phase_q != PH_IDLE, "summary from idle walker")
  `BTLP_ASSERT_ALWAYS(a_pos_aligned, pos_q[1:0] == 2'b00, "byte position not word aligned")
  `BTLP_ASSERT_IMP(a_body_in_tag, phase_q == PH_BODY, (pos_q - start_q) < tlen_q, "position past tag end")
  `BTLP_ASSERT_IMP(a_mmap_word, phase_q == PH_BODY && class_q == CL_MMAP, word_q <= MM_LAST, "map word index overrun")

endmodule

`default_nettype wire

// File: rtl/core/btlp_collect.sv
// Region slots, ELF bounds and error flags; builds the summary.
// Depends on btlp_pkg.
`default_nettype none

module btlp_collect
  import btlp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        fire_i,
  input  wire logic [31:0] word_i,
  input  wire walk_ctl_t   ctl_i,
  output summary_t         sum_o
);

  logic [63:0] addr_q [2];
  logic [63:0] addr_d [2];
  logic [63:0] len_q [2];
  logic [63:0] len_d [2];
  logic [1:0]  valid_q, valid_d;
  logic [1:0]  avail_q, avail_d;
  logic        extra_q, extra_d;
  logic [31:0] low_q, low_d;
  logic [63:0] ent_addr_q, ent_addr_d;
  logic [63:0] ent_len_q, ent_len_d;
  logic [63:0] elf_lo_q, elf_lo_d;
  logic [63:0] elf_hi_q, elf_hi_d;
  logic        size_err_q, size_err_d;

  logic [63:0] elf_size;
  logic [63:0] elf_end;
  logic        slot;

  assign elf_size = {word_i, low_q};
  assign elf_end  = ent_addr_q + elf_size;
  assign slot     = avail_q[0];

  always_comb begin
    addr_d     = addr_q;
    len_d      = len_q;
    valid_d    = valid_q;
    avail_d    = avail_q;
    extra_d    = extra_q;
    low_d      = low_q;
    ent_addr_d = ent_addr_q;
    ent_len_d  = ent_len_q;
    elf_lo_d   = elf_lo_q;
    elf_hi_d   = elf_hi_q;
    size_err_d = size_err_q;
    if (fire_i) begin
      if (ctl_i.clear) begin
        addr_d     = '{default: '0};
        len_d      = '{default: '0};
        valid_d    = '0;
        avail_d    = '0;
        extra_d    = 1'b0;
        low_d      = '0;
        ent_addr_d = '0;
        ent_len_d  = '0;
        elf_lo_d   = '1;
        elf_hi_d   = '0;
        size_err_d = 1'b0;
      end
      if (ctl_i.tag_begin) begin
        avail_d = '0;
      end
      if (ctl_i.size_err) begin
        size_err_d = 1'b1;
      end
      if (ctl_i.mmap_we) begin
        case (ctl_i.word)
          MM_ADDR_LO: low_d = word_i;
          MM_ADDR_HI: ent_addr_d = {word_i, low_q};
          MM_LEN_LO:  low_d = word_i;
          MM_LEN_HI:  ent_len_d = {word_i, low_q};
          MM_TYPE: begin
            if (word_i == REGION_AVAIL) begin
              if (avail_q < 2'd2) begin
                addr_d[slot]  = ent_addr_q;
                len_d[slot]   = ent_len_q;
                valid_d[slot] = 1'b1;
                avail_d       = avail_q + 2'd1;
              end else begin
                extra_d = 1'b1;
              end
            end
          end
          default: begin
          end
        endcase
      end
      if (ctl_i.elf_we) begin
        case (ctl_i.word)
          ELF_ADDR_LO: low_d = word_i;
          ELF_ADDR_HI: ent_addr_d = {word_i, low_q};
          ELF_SIZE_LO: low_d = word_i;
          ELF_SIZE_HI: begin
            if (ctl_i.elf_counted) begin
              if (ent_addr_q < elf_lo_q) begin
                elf_lo_d = ent_addr_q;
              end
              if (elf_end > elf_hi_q) begin
                elf_hi_d = elf_end;
              end
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q     <= '{default: '0};
      len_q      <= '{default: '0};
      valid_q    <= '0;
      avail_q    <= '0;
      extra_q    <= 1'b0;
      low_q      <= '0;
      ent_addr_q <= '0;
      ent_len_q  <= '0;
      elf_lo_q   <= '1;
      elf_hi_q   <= '0;
      size_err_q <= 1'b0;
    end else begin
      addr_q     <= addr_d;
      len_q      <= len_d;
      valid_q    <= valid_d;
      avail_q    <= avail_d;
      extra_q    <= extra_d;
      low_q      <= low_d;
      ent_addr_q <= ent_addr_d;
      ent_len_q  <= ent_len_d;
      elf_lo_q   <= elf_lo_d;
      elf_hi_q   <= elf_hi_d;
      size_err_q <= size_err_d;
    end
  end

  always_comb begin
    sum_o.region_one_base   = valid_d[0] ? addr_d[0] : '0;
    sum_o.region_one_length = valid_d[0] ? len_d[0] : '0;
    sum_o.region_two_base   = valid_d[1] ? addr_d[1] : '0;
    sum_o.region_two_length = valid_d[1] ? len_d[1] : '0;
    sum_o.regions_found     = {1'b0, valid_d[0]} + {1'b0, valid_d[1]};
    sum_o.extra_regions     = extra_d;
    sum_o.elf_low_address   = elf_lo_d;
    sum_o.elf_high_address  = elf_hi_d;
    sum_o.length_mismatch   = ctl_i.mismatch;
    sum_o.bad_tag_size      = size_err_d;
  end

endmodule

`default_nettype wire

// File: rtl/core/btlp_out_stage.sv
// Result register for the summary channel.
// Depends on btlp_pkg.
`default_nettype none

module btlp_out_stage
  import btlp_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     load_i,
  input  wire summary_t sum_i,
  output logic          advance_o,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output summary_t      sum_o
);

  logic     valid_q, valid_d;
  summary_t sum_q;

  assign advance_o = ~valid_q | ~out_stall_i;
  assign valid_d   = advance_o ? load_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && load_i) begin
      sum_q <= sum_i;
    end
  end

  assign out_valid_o = valid_q;
  assign sum_o       = sum_q;

endmodule

`default_nettype wire

// File: tb/tb_boot_tag_list_parser.sv
// Self-checking testbench for boot_tag_list_parser: walks boot information
// lists word by word and compares every summary beat with its own tag walker.
// Depends on btlp_pkg and the boot_tag_list_parser RTL.
module tb_boot_tag_list_parser;
  import btlp_pkg::*;

  localparam int RANDOM_WORDS     = 1060;
  localparam int CYCLE_LIMIT      = 400000;
  localparam int DRAIN_CYCLES     = 8;
  localparam int LONG_HOLD        = 200;
  localparam int MMAP_HDR_BYTES   = 16;
  localparam int MMAP_ENTRY_BYTES = 24;
  localparam int ELF_HDR_BYTES    = 20;
  localparam int ELF_ENTRY_BYTES  = 64;
  localparam int ELF_ENTRY_WORDS  = 16;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] data_word = '0;
  logic        first_word = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] region_one_base;
  logic [63:0] region_one_length;
  logic [63:0] region_two_base;
  logic [63:0] region_two_length;
  logic [1:0]  regions_found;
  logic        extra_regions;
  logic [63:0] elf_low_address;
  logic [63:0] elf_high_address;
  logic        length_mismatch;
  logic        bad_tag_size;

  boot_tag_list_parser DUT (
    .clk_i                (clk),
    .rst_ni               (rst_n),
    .in_valid_i           (in_valid),
    .in_stall_o           (in_stall),
    .data_word_i          (data_word),
    .first_word_i         (first_word),
    .out_valid_o          (out_valid),
    .out_stall_i          (out_stall),
    .region_one_base_o    (region_one_base),
    .region_one_length_o  (region_one_length),
    .region_two_base_o    (region_two_base),
    .region_two_length_o  (region_two_length),
    .regions_found_o      (regions_found),
    .extra_regions_o      (extra_regions),
    .elf_low_address_o    (elf_low_address),
    .elf_high_address_o   (elf_high_address),
    .length_mismatch_o    (length_mismatch),
    .bad_tag_size_o       (bad_tag_size)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // walker state
  phase_e      walk_phase;
  class_e      walk_class;
  logic [31:0] walk_pos;
  logic [31:0] walk_total;
  logic [31:0] walk_tag_start;
  logic [31:0] walk_tag_len;
  logic [3:0]  entry_word;
  logic [31:0] entry_limit;
  logic [31:0] entry_idx;
  logic [1:0]  tag_avail;
  logic [31:0] half_hold;
  logic [63:0] addr_hold;
  logic [63:0] len_hold;
  logic [63:0] slot_addr [2];
  logic [63:0] slot_len [2];
  logic [1:0]  slot_filled;
  logic        extra_flag;
  logic [63:0] elf_lo;
  logic [63:0] elf_hi;
  logic        size_bad;

  summary_t    pending_summaries[$];
  logic [31:0] list_words[$];

  int mismatches = 0;
  int words_used = 0;
  int summaries_made = 0;
  int cycle_count = 0;
  int hold_requests = 0;
  int holds_served = 0;
  int hold_left = 0;
  int stall_run = 0;
  bit tx_jitter = 1'b1;
  bit rx_jitter = 1'b1;

  function automatic void clear_walk();
    walk_phase     = PH_IDLE;
    walk_class     = CL_OTHER;
    walk_pos       = '0;
    walk_total     = '0;
    walk_tag_start = '0;
    walk_tag_len   = '0;
    entry_word     = '0;
    entry_limit    = '0;
    entry_idx      = '0;
    tag_avail      = '0;
    half_hold      = '0;
    addr_hold      = '0;
    len_hold       = '0;
    slot_addr[0]   = '0;
    slot_addr[1]   = '0;
    slot_len[0]    = '0;
    slot_len[1]    = '0;
    slot_filled    = '0;
    extra_flag     = 1'b0;
    elf_lo         = '1;
    elf_hi         = '0;
    size_bad       = 1'b0;
  endfunction

  function automatic void emit_summary(input bit mismatch);
    summary_t s;
    s.region_one_base   = slot_filled[0] ? slot_addr[0] : '0;
    s.region_one_length = slot_filled[0] ? slot_len[0] : '0;
    s.region_two_base   = slot_filled[1] ? slot_addr[1] : '0;
    s.region_two_length = slot_filled[1] ? slot_len[1] : '0;
    s.regions_found     = {1'b0, slot_filled[0]} + {1'b0, slot_filled[1]};
    s.extra_regions     = extra_flag;
    s.elf_low_address   = elf_lo;
    s.elf_high_address  = elf_hi;
    s.length_mismatch   = mismatch;
    s.bad_tag_size      = size_bad;
    pending_summaries.push_back(s);
    summaries_made++;
    walk_phase = PH_IDLE;
  endfunction

  function automatic void next_tag_or_end(input bit wrapped);
    if (!wrapped && walk_pos < walk_total) begin
      walk_tag_start = walk_pos;
      walk_phase     = PH_TYPE;
    end else begin
      emit_summary(wrapped || walk_pos != walk_total);
    end
  endfunction

  function automatic void mmap_entry_word(input logic [31:0] w);
    case (entry_word)
      MM_ADDR_LO, MM_LEN_LO: half_hold = w;
      MM_ADDR_HI: addr_hold = {w, half_hold};
      MM_LEN_HI: len_hold = {w, half_hold};
      MM_TYPE: begin
        if (w == REGION_AVAIL) begin
          if (tag_avail < 2'd2) begin
            slot_addr[tag_avail[0]]   = addr_hold;
            slot_len[tag_avail[0]]    = len_hold;
            slot_filled[tag_avail[0]] = 1'b1;
            tag_avail++;
          end else begin
            extra_flag = 1'b1;
          end
        end
      end
      default: ;
    endcase
    entry_word++;
    if (entry_word > MM_LAST) begin
      entry_word = '0;
      entry_idx++;
    end
  endfunction

  function automatic void elf_entry_word(input logic [31:0] w);
    logic [63:0] sz;
    logic [63:0] top;
    case (entry_word)
      ELF_ADDR_LO, ELF_SIZE_LO: half_hold = w;
      ELF_ADDR_HI: addr_hold = {w, half_hold};
      ELF_SIZE_HI: begin
        if (entry_idx != 0) begin
          sz  = {w, half_hold};
          top = addr_hold + sz;
          if (addr_hold < elf_lo) elf_lo = addr_hold;
          if (top > elf_hi) elf_hi = top;
        end
      end
      default: ;
    endcase
    entry_word++;
    if (entry_word == 4'd0) entry_idx++;
  endfunction

  function automatic void advance_walk(input logic [31:0] w, input logic first);
    logic [31:0] rounded;
    logic [31:0] d;
    logic [31:0] tag_end;
    if (first) begin
      clear_walk();
      walk_total = w;
      walk_pos   = 32'd4;
      walk_phase = PH_HDR;
      return;
    end
    case (walk_phase)
      PH_HDR: begin
        walk_pos = 32'd8;
        next_tag_or_end(1'b0);
      end
      PH_TYPE: begin
        walk_class = (w == TAG_TYPE_END) ? CL_END :
                     (w == TAG_TYPE_MMAP) ? CL_MMAP :
                     (w == TAG_TYPE_ELF) ? CL_ELF : CL_OTHER;
        walk_pos  += 32'd4;
        walk_phase = PH_SIZE;
      end
      PH_SIZE: begin
        rounded   = (w + 32'd7) & ~32'd7;
        walk_pos += 32'd4;
        if (w < MIN_TAG_SIZE || rounded == 0) begin
          size_bad = 1'b1;
          emit_summary(walk_pos != walk_total);
        end else begin
          walk_tag_len = rounded;
          if (walk_class == CL_END) begin
            tag_end  = walk_tag_start + rounded;
            walk_pos = tag_end;
            emit_summary(tag_end < walk_tag_start || tag_end != walk_total);
          end else begin
            case (walk_class)
              CL_MMAP: entry_limit = (w >= MMAP_HDR_BYTES) ?
                                     (w - MMAP_HDR_BYTES) / MMAP_ENTRY_BYTES : '0;
              CL_ELF:  entry_limit = (w >= ELF_HDR_BYTES) ?
                                     (w - ELF_HDR_BYTES) / ELF_ENTRY_BYTES : '0;
              default: entry_limit = '0;
            endcase
            entry_idx  = '0;
            entry_word = '0;
            tag_avail  = '0;
            walk_phase = PH_BODY;
            if (rounded == MIN_TAG_SIZE) begin
              walk_pos = walk_tag_start + MIN_TAG_SIZE;
              next_tag_or_end(walk_pos < walk_tag_start);
            end
          end
        end
      end
      PH_BODY: begin
        d = (walk_pos - walk_tag_start - 32'd8) >> 2;
        if (walk_class == CL_MMAP) begin
          if (d >= 2 && entry_idx < entry_limit) mmap_entry_word(w);
        end else if (walk_class == CL_ELF) begin
          if (d == 0) begin
            if (w < entry_limit) entry_limit = w;
          end else if (d >= 3 && entry_idx < entry_limit) begin
            elf_entry_word(w);
          end
        end
        walk_pos += 32'd4;
        if (walk_pos - walk_tag_start == walk_tag_len) next_tag_or_end(walk_pos < walk_tag_start);
      end
      default: ;
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [63:0] rand64();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send_word(input logic [31:0] w, input logic first);
    int gap;
    gap = tx_jitter ? pick_gap() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    data_word  <= w;
    first_word <= first;
    do @(posedge clk); while (in_stall);
    if (first || walk_phase != PH_IDLE) words_used++;
    advance_walk(w, first);
  endtask

  task automatic send_list(input int count);
    int i;
    for (i = 0; i < count; i++) send_word(list_words[i], i == 0);
  endtask

  function automatic void open_list();
    list_words.delete();
    list_words.push_back(32'd0);
    list_words.push_back($urandom);
  endfunction

  function automatic void pad_tag(input int at, input logic [31:0] size);
    logic [31:0] rounded;
    rounded = (size + 32'd7) & ~32'd7;
    while (list_words.size() - at < rounded / 4) list_words.push_back($urandom);
  endfunction

  function automatic void add_other_tag();
    int at;
    logic [31:0] kind;
    logic [31:0] size;
    at = list_words.size();
    do begin
      kind = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1, 12);
    end while (kind == TAG_TYPE_END || kind == TAG_TYPE_MMAP || kind == TAG_TYPE_ELF);
    size = $urandom_range(8, 40);
    list_words.push_back(kind);
    list_words.push_back(size);
    pad_tag(at, size);
  endfunction

  function automatic void add_mmap_tag();
    int at;
    int n;
    int e;
    int r;
    logic [31:0] size;
    logic [63:0] addr;
    logic [63:0] len;
    at = list_words.size();
    if ($urandom_range(0, 15) == 0) begin
      size = $urandom_range(8, MMAP_HDR_BYTES - 1);
      list_words.push_back(TAG_TYPE_MMAP);
      list_words.push_back(size);
      pad_tag(at, size);
      return;
    end
    n    = $urandom_range(0, 4);
    size = MMAP_HDR_BYTES + MMAP_ENTRY_BYTES * n;
    if ($urandom_range(0, 3) == 0) size += $urandom_range(1, 7);
    list_words.push_back(TAG_TYPE_MMAP);
    list_words.push_back(size);
    list_words.push_back(MMAP_ENTRY_BYTES);
    list_words.push_back($urandom);
    for (e = 0; e < n; e++) begin
      addr = rand64();
      len  = rand64();
      r    = $urandom_range(0, 99);
      list_words.push_back(addr[31:0]);
      list_words.push_back(addr[63:32]);
      list_words.push_back(len[31:0]);
      list_words.push_back(len[63:32]);
      if (r < 55) list_words.push_back(REGION_AVAIL);
      else if (r < 85) list_words.push_back($urandom_range(2, 5));
      else list_words.push_back($urandom);
      list_words.push_back($urandom);
    end
    pad_tag(at, size);
  endfunction

  function automatic void add_elf_tag();
    int at;
    int n;
    int e;
    int j;
    int r;
    logic [31:0] size;
    logic [63:0] addr;
    logic [63:0] sz;
    at = list_words.size();
    if ($urandom_range(0, 15) == 0) begin
      size = $urandom_range(8, ELF_HDR_BYTES - 1);
      list_words.push_back(TAG_TYPE_ELF);
      list_words.push_back(size);
      pad_tag(at, size);
      return;
    end
    n    = $urandom_range(0, 2);
    size = ELF_HDR_BYTES + ELF_ENTRY_BYTES * n;
    if ($urandom_range(0, 3) == 0) size += $urandom_range(1, 7);
    r = $urandom_range(0, 99);
    list_words.push_back(TAG_TYPE_ELF);
    list_words.push_back(size);
    if (r < 70) list_words.push_back(n);
    else if (r < 85) list_words.push_back($urandom_range(0, n));
    else list_words.push_back($urandom);
    list_words.push_back(ELF_ENTRY_BYTES);
    list_words.push_back($urandom);
    for (e = 0; e < n; e++) begin
      addr = rand64();
      sz   = ($urandom_range(0, 3) == 0) ? rand64() : {32'd0, $urandom_range(0, 65535)};
      for (j = 0; j < ELF_ENTRY_WORDS; j++) begin
        case (j)
          ELF_ADDR_LO: list_words.push_back(addr[31:0]);
          ELF_ADDR_HI: list_words.push_back(addr[63:32]);
          ELF_SIZE_LO: list_words.push_back(sz[31:0]);
          ELF_SIZE_HI: list_words.push_back(sz[63:32]);
          default:     list_words.push_back($urandom);
        endcase
      end
    end
    pad_tag(at, size);
  endfunction

  function automatic void add_end_tag();
    list_words.push_back(TAG_TYPE_END);
    if ($urandom_range(0, 4) == 0) begin
      list_words.push_back(32'd16);
      list_words.push_back($urandom);
      list_words.push_back($urandom);
    end else begin
      list_words.push_back(MIN_TAG_SIZE);
    end
  endfunction

  function automatic void close_list(input bit exact);
    logic [31:0] total;
    total = list_words.size() * 4;
    if (!exact) begin
      case ($urandom_range(0, 2))
        0: total += 8 * $urandom_range(1, 3);
        1: total -= 8 * $urandom_range(1, 3);
        default: total = $urandom;
      endcase
    end
    list_words[0] = total;
  endfunction

  function automatic void add_random_tags(input int count);
    int t;
    for (t = 0; t < count; t++) begin
      case ($urandom_range(0, 2))
        0: add_other_tag();
        1: add_mmap_tag();
        default: add_elf_tag();
      endcase
    end
  endfunction

  task automatic send_random_list();
    open_list();
    add_random_tags($urandom_range(1, 3));
    if ($urandom_range(0, 3) != 0) add_end_tag();
    close_list($urandom_range(0, 4) != 0);
    send_list(list_words.size());
  endtask

  task automatic send_broken_list();
    open_list();
    add_random_tags($urandom_range(0, 2));
    if ($urandom_range(0, 1) == 0) begin
      list_words.push_back($urandom_range(0, 12));
      if ($urandom_range(0, 1) == 0) list_words.push_back($urandom_range(0, 7));
      else list_words.push_back($urandom_range(32'hFFFF_FFF9, 32'hFFFF_FFFF));
      close_list($urandom_range(0, 2) != 0);
      send_list(list_words.size());
    end else begin
      // cut the list short; the next list restarts the walk
      add_end_tag();
      close_list(1'b1);
      send_list($urandom_range(1, list_words.size() - 1));
    end
  endtask

  task automatic send_noise();
    int n;
    int i;
    n = $urandom_range(4, 16);
    for (i = 0; i < n; i++) send_word($urandom, $urandom_range(0, 15) == 0);
  endtask

  task automatic test_idle_words();
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word(32'h0000_0000, 1'b0);
  endtask

  task automatic test_header_only();
    send_word(32'd8, 1'b1);
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word(32'd0, 1'b1);
    send_word(32'd0, 1'b0);
  endtask

  task automatic test_bad_sizes();
    send_word(32'd16, 1'b1);
    send_word(32'd0, 1'b0);
    send_word(32'd5, 1'b0);
    send_word(32'd7, 1'b0);
    send_word(32'd32, 1'b1);
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word(TAG_TYPE_ELF, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b0);
  endtask

  task automatic test_terminator();
    send_word(32'd16, 1'b1);
    send_word(32'd0, 1'b0);
    send_word(TAG_TYPE_END, 1'b0);
    send_word(MIN_TAG_SIZE, 1'b0);
    // tag end wraps past the top of the byte space
    send_word(32'hFFFF_FFFF, 1'b1);
    send_word(32'd0, 1'b0);
    send_word(TAG_TYPE_END, 1'b0);
    send_word(32'hFFFF_FFF8, 1'b0);
  endtask

  task automatic test_restart();
    send_word(32'd24, 1'b1);
    send_word(32'd0, 1'b0);
    send_word(TAG_TYPE_MMAP, 1'b0);
    send_word(32'd16, 1'b1);
    send_word(32'd0, 1'b0);
    send_word(TAG_TYPE_END, 1'b0);
    send_word(MIN_TAG_SIZE, 1'b0);
  endtask

  task automatic test_backpressure();
    int i;
    tx_jitter = 1'b0;
    hold_requests++;
    for (i = 0; i < 8; i++) begin
      open_list();
      add_end_tag();
      close_list(1'b1);
      send_list(list_words.size());
    end
    tx_jitter = 1'b1;
  endtask

  task automatic test_random_traffic();
    int pick;
    words_used     = 0;
    summaries_made = 0;
    while (words_used < RANDOM_WORDS) begin
      tx_jitter = $urandom_range(0, 4) != 0;
      rx_jitter = $urandom_range(0, 4) != 0;
      pick = $urandom_range(0, 99);
      if (pick < 75) send_random_list();
      else if (pick < 90) send_broken_list();
      else send_noise();
    end
  endtask

  always @(posedge clk) begin
    if (hold_requests != holds_served) begin
      hold_left = LONG_HOLD;
      holds_served++;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_run != 0) begin
      stall_run--;
      out_stall <= 1'b1;
    end else if (rx_jitter && $urandom_range(0, 3) == 0) begin
      stall_run = pick_gap();
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    summary_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_summaries.size() == 0) begin
        $display("%0t: summary beat with none expected", $time);
        mismatches++;
      end else begin
        want = pending_summaries.pop_front();
        check_field("region_one_base", want.region_one_base, region_one_base);
        check_field("region_one_length", want.region_one_length, region_one_length);
        check_field("region_two_base", want.region_two_base, region_two_base);
        check_field("region_two_length", want.region_two_length, region_two_length);
        check_field("regions_found", want.regions_found, regions_found);
        check_field("extra_regions", want.extra_regions, extra_regions);
        check_field("elf_low_address", want.elf_low_address, elf_low_address);
        check_field("elf_high_address", want.elf_high_address, elf_high_address);
        check_field("length_mismatch", want.length_mismatch, length_mismatch);
        check_field("bad_tag_size", want.bad_tag_size, bad_tag_size);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    clear_walk();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_idle_words();
    test_header_only();
    test_bad_sizes();
    test_terminator();
    test_restart();
    test_backpressure();
    test_random_traffic();
    in_valid <= 1'b0;
    while (pending_summaries.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_summaries.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
